FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, muted while reset is high
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/slcfp_pkg.sv
// ----------------------------------------------------------------------------
// slcfp_pkg
// types, codes and the crc-16 byte update of the frame parser
// ----------------------------------------------------------------------------
package slcfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [7:0]  SYNC_RESET    = 8'hAA;
  localparam logic [7:0]  VERSION_RESET = 8'h01;
  localparam logic [10:0] MAX_LEN_RESET = 11'd1024;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [7:0]  version_value;
    logic [10:0] max_payload_len;
  } cfg_t;

  typedef enum logic [8:0] {
    PH_SYNC  = 9'b000000001,
    PH_VER   = 9'b000000010,
    PH_CHAN  = 9'b000000100,
    PH_SEQ   = 9'b000001000,
    PH_LENHI = 9'b000010000,
    PH_LENLO = 9'b000100000,
    PH_PAY   = 9'b001000000,
    PH_CRCHI = 9'b010000000,
    PH_CRCLO = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_PAY  = 3'd1,
    EV_GOOD = 3'd2,
    EV_VER  = 3'd3,
    EV_LEN  = 3'd4,
    EV_CRC  = 3'd5
  } event_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/slcfp_byte_if.sv
// ----------------------------------------------------------------------------
// slcfp_byte_if
// valid/ready channel carrying one received byte
// ----------------------------------------------------------------------------
interface slcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

FILE: rtl/slcfp_event_if.sv
// ----------------------------------------------------------------------------
// slcfp_event_if
// valid/ready channel carrying one parser event
// ----------------------------------------------------------------------------
interface slcfp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  channel_id;
  logic [7:0]  sequence_no;
  logic [10:0] frame_length;
  logic [7:0]  data_byte;
  logic [9:0]  byte_index;
  logic        last_payload;

  modport source (
    output valid, output event_res, output channel_id, output sequence_no,
    output frame_length, output data_byte, output byte_index, output last_payload,
    input ready
  );
  modport sink (
    input valid, input event_res, input channel_id, input sequence_no,
    input frame_length, input data_byte, input byte_index, input last_payload,
    output ready
  );
endinterface

FILE: rtl/slcfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// slcfp_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module slcfp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [slcfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slcfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output slcfp_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value      <= slcfp_pkg::SYNC_RESET;
      cfg.version_value   <= slcfp_pkg::VERSION_RESET;
      cfg.max_payload_len <= slcfp_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        slcfp_pkg::CFG_SYNC:    cfg.sync_value      <= cfg_data[7:0];
        slcfp_pkg::CFG_VERSION: cfg.version_value   <= cfg_data[7:0];
        slcfp_pkg::CFG_MAX_LEN: cfg.max_payload_len <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/slcfp_parser.sv
// ----------------------------------------------------------------------------
// slcfp_parser
// per-byte frame state step, crc update and registered event output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slcfp_parser #(
  parameter int unsigned MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst,
  input  slcfp_pkg::cfg_t   cfg,
  slcfp_byte_if.sink        in_ch,
  slcfp_event_if.source     out_ch
);

  localparam logic [15:0] MaxPay = 16'(MAX_PAYLOAD);

  slcfp_pkg::phase_t phase, phase_next;
  logic [7:0]  held_channel, held_channel_next;
  logic [7:0]  held_sequence, held_sequence_next;
  logic [15:0] held_length, held_length_next;
  logic [10:0] payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high, crc_high_next;

  slcfp_pkg::event_t ev;
  logic [7:0]  dbyte;
  logic [9:0]  didx;
  logic        dlast;
  logic [15:0] limit;
  logic [15:0] len_lo;
  logic [10:0] count_inc;
  logic [15:0] crc_upd;
  logic [15:0] crc_first;
  logic [7:0]  b;
  logic        accept;

  assign b       = in_ch.byte_in;
  assign accept  = in_ch.valid && in_ch.ready;
  // output register frees up when empty or being drained
  assign in_ch.ready = !out_ch.valid || out_ch.ready;

  assign crc_upd   = slcfp_pkg::crc16_byte(running_crc, b);
  assign crc_first = slcfp_pkg::crc16_byte(slcfp_pkg::CRC_INIT, b);
  assign limit     = ({5'd0, cfg.max_payload_len} > MaxPay) ? MaxPay
                                                            : {5'd0, cfg.max_payload_len};
  assign len_lo    = {held_length[15:8], b};
  assign count_inc = payload_count + 11'd1;

  always_comb begin
    phase_next         = phase;
    held_channel_next  = held_channel;
    held_sequence_next = held_sequence;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    crc_high_next      = crc_high;
    ev    = slcfp_pkg::EV_NONE;
    dbyte = 8'd0;
    didx  = 10'd0;
    dlast = 1'b0;
    case (phase)
      slcfp_pkg::PH_VER: begin
        if (b != cfg.version_value) begin
          ev         = slcfp_pkg::EV_VER;
          phase_next = (b == cfg.sync_value) ? slcfp_pkg::PH_VER : slcfp_pkg::PH_SYNC;
        end else begin
          running_crc_next = crc_first;
          phase_next       = slcfp_pkg::PH_CHAN;
        end
      end
      slcfp_pkg::PH_CHAN: begin
        held_channel_next = b;
        running_crc_next  = crc_upd;
        phase_next        = slcfp_pkg::PH_SEQ;
      end
      slcfp_pkg::PH_SEQ: begin
        held_sequence_next = b;
        running_crc_next   = crc_upd;
        phase_next         = slcfp_pkg::PH_LENHI;
      end
      slcfp_pkg::PH_LENHI: begin
        held_length_next = {b, 8'd0};
        running_crc_next = crc_upd;
        phase_next       = slcfp_pkg::PH_LENLO;
      end
      slcfp_pkg::PH_LENLO: begin
        held_length_next = len_lo;
        running_crc_next = crc_upd;
        if (len_lo > limit) begin
          ev         = slcfp_pkg::EV_LEN;
          phase_next = slcfp_pkg::PH_SYNC;
        end else begin
          payload_count_next = 11'd0;
          phase_next = (len_lo == 16'd0) ? slcfp_pkg::PH_CRCHI : slcfp_pkg::PH_PAY;
        end
      end
      slcfp_pkg::PH_PAY: begin
        running_crc_next   = crc_upd;
        ev                 = slcfp_pkg::EV_PAY;
        dbyte              = b;
        didx               = payload_count[9:0];
        payload_count_next = count_inc;
        if ({5'd0, count_inc} >= held_length) begin
          dlast      = 1'b1;
          phase_next = slcfp_pkg::PH_CRCHI;
        end
      end
      slcfp_pkg::PH_CRCHI: begin
        crc_high_next = b;
        phase_next    = slcfp_pkg::PH_CRCLO;
      end
      slcfp_pkg::PH_CRCLO: begin
        ev = ({crc_high, b} == running_crc) ? slcfp_pkg::EV_GOOD : slcfp_pkg::EV_CRC;
        phase_next = slcfp_pkg::PH_SYNC;
      end
      default: begin
        phase_next = (b == cfg.sync_value) ? slcfp_pkg::PH_VER : slcfp_pkg::PH_SYNC;
      end
    endcase
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= slcfp_pkg::PH_SYNC;
      held_channel  <= 8'd0;
      held_sequence <= 8'd0;
      held_length   <= 16'd0;
      payload_count <= 11'd0;
      running_crc   <= 16'd0;
      crc_high      <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      held_channel  <= held_channel_next;
      held_sequence <= held_sequence_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      crc_high      <= crc_high_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.event_res    <= ev;
      out_ch.channel_id   <= held_channel_next;
      out_ch.sequence_no  <= held_sequence_next;
      out_ch.frame_length <= (|held_length_next[15:11]) ? 11'h7FF : held_length_next[10:0];
      out_ch.data_byte    <= dbyte;
      out_ch.byte_index   <= didx;
      out_ch.last_payload <= dlast;
    end
  end

  `ASSERT_CLKD(a_accept_gives_result, clk, rst,
    $past(accept) |-> out_ch.valid, "accepted item left no result")
  `ASSERT_CLKD(a_payload_fields_clear, clk, rst,
    (out_ch.valid && out_ch.event_res != slcfp_pkg::EV_PAY) |->
    (out_ch.data_byte == 8'd0 && out_ch.byte_index == 10'd0 && !out_ch.last_payload),
    "payload fields set on a non-payload event")
  `ASSERT_CLKD(a_last_matches_length, clk, rst,
    (out_ch.valid && out_ch.last_payload) |->
    (out_ch.event_res == slcfp_pkg::EV_PAY &&
     out_ch.frame_length[9:0] == out_ch.byte_index + 10'd1),
    "last payload byte does not match frame length")

endmodule

FILE: rtl/sync_length_crc_frame_parser_top.sv
// ----------------------------------------------------------------------------
// sync_length_crc_frame_parser_top
// byte-stream frame parser: sync, version, header, payload, crc-16 check
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one event item per
// byte, registered, at a sustained rate of one item per cycle while the
// receiver keeps ready up; each step holds one crc-16/ccitt-false byte
// update (eight shift steps of the polynomial) with the frame state step.
// The output register decouples the two channels: a new byte is taken
// whenever the result register is empty or being drained in the same
// cycle. Frame on the wire: sync, version, channel, sequence, length high,
// length low, payload, crc high, crc low; the crc covers version through
// payload. Configuration writes take effect on the next byte and are meant
// to be issued while the parser is idle.

module sync_length_crc_frame_parser_top #(
  parameter int unsigned MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [slcfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slcfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // received bytes in, parser events out
  slcfp_byte_if.sink                         byte_ch,
  slcfp_event_if.source                      event_ch
);

  // live register values, sync byte, version byte and length limit
  slcfp_pkg::cfg_t cfg;

  slcfp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // per-byte state step, crc and result register
  slcfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (byte_ch),
    .out_ch (event_ch)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sync / length / crc-16 frame parser
// ----------------------------------------------------------------------------
// Feeds byte streams of well-formed frames with random content, mixed with
// broken frames and line noise, under several register settings. A parser
// model in the scoreboard predicts one event item per accepted byte; every
// event item leaving the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import slcfp_pkg::*;

  localparam int          CYCLE_LIMIT  = 100000;
  localparam int          STALL_CYCLES = 80;
  localparam logic [15:0] CCITT_POLY   = 16'h1021;
  localparam logic [15:0] CCITT_SEED   = 16'hFFFF;

  // one predicted or observed event item
  typedef struct packed {
    event_t      kind;
    logic [7:0]  chan;
    logic [7:0]  seq;
    logic [10:0] length;
    logic [7:0]  data;
    logic [9:0]  pos;
    logic        is_last;
  } parser_event_t;

  // crc-16/ccitt-false, fed msb first one bit at a time
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CCITT_POLY;
      end
    end
    return c;
  endfunction

  // parser model plus the queue of events still owed by the block
  class frame_scoreboard;
    parser_event_t expected_q[$];
    int            errors;
    logic [7:0]    sync_byte;
    logic [7:0]    version_byte;
    logic [10:0]   len_cap;
    phase_t        phase;
    logic [7:0]    chan;
    logic [7:0]    seq;
    logic [15:0]   len;
    logic [15:0]   count;
    logic [15:0]   crc;
    logic [7:0]    crc_hi;

    function new();
      errors       = 0;
      sync_byte    = 8'hAA;
      version_byte = 8'h01;
      len_cap      = 11'd1024;
      phase        = PH_SYNC;
      chan         = '0;
      seq          = '0;
      len          = '0;
      count        = '0;
      crc          = '0;
      crc_hi       = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SYNC:    sync_byte    = val[7:0];
        CFG_VERSION: version_byte = val[7:0];
        CFG_MAX_LEN: len_cap      = val[10:0];
        default: ;
      endcase
    endfunction

    function int limit();
      return (len_cap > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_cap);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the model by one accepted byte and queue its event
    function void note_byte(logic [7:0] b);
      parser_event_t r;
      r = '0;
      r.kind = EV_NONE;
      case (phase)
        PH_VER: begin
          if (b != version_byte) begin
            r.kind = EV_VER;
            phase  = (b == sync_byte) ? PH_VER : PH_SYNC;
          end else begin
            crc   = crc_step(CCITT_SEED, b);
            phase = PH_CHAN;
          end
        end
        PH_CHAN: begin
          chan  = b;
          crc   = crc_step(crc, b);
          phase = PH_SEQ;
        end
        PH_SEQ: begin
          seq   = b;
          crc   = crc_step(crc, b);
          phase = PH_LENHI;
        end
        PH_LENHI: begin
          len   = {b, 8'h00};
          crc   = crc_step(crc, b);
          phase = PH_LENLO;
        end
        PH_LENLO: begin
          len[7:0] = b;
          crc      = crc_step(crc, b);
          if (int'(len) > limit()) begin
            r.kind = EV_LEN;
            phase  = PH_SYNC;
          end else begin
            count = '0;
            phase = (len == 16'd0) ? PH_CRCHI : PH_PAY;
          end
        end
        PH_PAY: begin
          crc    = crc_step(crc, b);
          r.kind = EV_PAY;
          r.data = b;
          r.pos  = count[9:0];
          count  = count + 16'd1;
          if (count >= len) begin
            r.is_last = 1'b1;
            phase     = PH_CRCHI;
          end
        end
        PH_CRCHI: begin
          crc_hi = b;
          phase  = PH_CRCLO;
        end
        PH_CRCLO: begin
          if ({crc_hi, b} == crc) begin
            r.kind = EV_GOOD;
          end else begin
            r.kind = EV_CRC;
          end
          phase = PH_SYNC;
        end
        default: phase = (b == sync_byte) ? PH_VER : PH_SYNC;
      endcase
      r.chan   = chan;
      r.seq    = seq;
      r.length = (len > 16'h07FF) ? 11'h7FF : len[10:0];
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_event(parser_event_t got);
      parser_event_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t unexpected event %0h with nothing pending", $time, got.kind);
        end
        return;
      end
      want = expected_q.pop_front();
      compare_field("event_res", 16'(want.kind), 16'(got.kind));
      compare_field("channel_id", 16'(want.chan), 16'(got.chan));
      compare_field("sequence_no", 16'(want.seq), 16'(got.seq));
      compare_field("frame_length", 16'(want.length), 16'(got.length));
      compare_field("data_byte", 16'(want.data), 16'(got.data));
      compare_field("byte_index", 16'(want.pos), 16'(got.pos));
      compare_field("last_payload", 16'(want.is_last), 16'(got.is_last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slcfp_byte_if  byte_ch();
  slcfp_event_if event_ch();

  frame_scoreboard sb;
  int              bytes_sent = 0;
  int              cycle_count = 0;
  bit              quiet = 1'b0;     // no idling on either side while set
  bit              hold_req = 1'b0;  // asks the receiver for one long stall

  sync_length_crc_frame_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_ch   (byte_ch),
    .event_ch  (event_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit, counted in cycles
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random ready, plus one long hold-off on request
  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        event_ch.ready <= 1'b0;
        // the parser fills its output register and then stalls its input
        repeat (STALL_CYCLES - 1) @(posedge clk);
      end else begin
        event_ch.ready <= quiet || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // every event item taken by the receiver is checked at the edge it moves
  always @(posedge clk) begin
    parser_event_t got;
    if (!rst && event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
      got.kind    = event_t'(event_ch.event_res);
      got.chan    = event_ch.channel_id;
      got.seq     = event_ch.sequence_no;
      got.length  = event_ch.frame_length;
      got.data    = event_ch.data_byte;
      got.pos     = event_ch.byte_index;
      got.is_last = event_ch.last_payload;
      sb.check_event(got);
    end
  end

  // offer one byte, with random idle cycles ahead of it, until accepted
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // stop offering and wait until every predicted event has come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // settling margin after the last event has left
    repeat (4) @(posedge clk);
  endtask

  // all three registers, one write per edge, enable dropped once at the end
  task automatic program_regs(input logic [7:0] sync_v, input logic [7:0] ver_v,
                              input logic [10:0] max_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC;
    cfg_data  <= {3'b000, sync_v};
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_data  <= {3'b000, ver_v};
    @(posedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_data  <= max_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_SYNC, {3'b000, sync_v});
    sb.set_reg(CFG_VERSION, {3'b000, ver_v});
    sb.set_reg(CFG_MAX_LEN, max_v);
  endtask

  // one frame under the current settings; an oversize length ends it after
  // the header, and only the first cut payload bytes are sent
  task automatic send_frame(input bit stray, input logic [7:0] chan, input logic [7:0] seq,
                            input logic [15:0] len, input bit bad_crc, input int cut);
    logic [15:0] crc;
    logic [7:0]  b;
    int          i;
    send_byte(sb.sync_byte);
    if (stray) begin
      send_byte(sb.sync_byte);
    end
    crc = crc_step(CCITT_SEED, sb.version_byte);
    send_byte(sb.version_byte);
    crc = crc_step(crc, chan);
    send_byte(chan);
    crc = crc_step(crc, seq);
    send_byte(seq);
    crc = crc_step(crc, len[15:8]);
    send_byte(len[15:8]);
    crc = crc_step(crc, len[7:0]);
    send_byte(len[7:0]);
    if (int'(len) > sb.limit()) begin
      return;
    end
    for (i = 0; i < int'(len); i++) begin
      if (i >= cut) begin
        return;
      end
      b   = 8'($urandom);
      crc = crc_step(crc, b);
      send_byte(b);
    end
    if (bad_crc) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // mostly short payloads, sometimes empty, sometimes exactly at a small limit
  function automatic logic [15:0] pick_length(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 12) begin
      return 16'd0;
    end
    if (r < 22 && lim <= 32) begin
      return lim[15:0];
    end
    return 16'($urandom_range(1, (lim < 16) ? lim : 16));
  endfunction

  // one random stretch of the line: mostly well-formed frames
  task automatic random_segment();
    int          pick;
    int          lim;
    int          cut;
    logic [15:0] len;
    logic [7:0]  v;
    lim  = sb.limit();
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      // full frame, crc now and then corrupted
      len = pick_length(lim);
      send_frame(1'b0, 8'($urandom), 8'($urandom), len, $urandom_range(0, 99) < 12,
                 int'(len));
    end else if (pick < 74) begin
      // wrong version; may itself be the sync byte
      send_byte(sb.sync_byte);
      do v = 8'($urandom); while (v == sb.version_byte);
      send_byte(v);
    end else if (pick < 80) begin
      // repeated sync ahead of the version
      len = pick_length(lim);
      send_frame(1'b1, 8'($urandom), 8'($urandom), len, 1'b0, int'(len));
    end else if (pick < 86) begin
      // length just over the limit or far beyond it
      if ($urandom_range(0, 1) == 0) begin
        len = 16'(lim + 1);
      end else begin
        len = 16'($urandom_range(lim + 1, 65535));
      end
      send_frame(1'b0, 8'($urandom), 8'($urandom), len, 1'b0, 0);
    end else if (pick < 92) begin
      // frame cut short; following bytes land in its payload
      len = pick_length(lim);
      cut = (len == 16'd0) ? 0 : $urandom_range(0, int'(len) - 1);
      send_frame(1'b0, 8'($urandom), 8'($urandom), len, 1'b0, cut);
    end else begin
      // line noise
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) random_segment();
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] v;
    sb              = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SYNC;
    cfg_data        = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: sync 0xaa, version 0x01, limit 1024
    // good frame with no payload, crc right after the length
    send_frame(1'b0, 8'hFF, 8'h00, 16'd0, 1'b0, 0);
    // wrong version, back to hunting
    send_byte(sb.sync_byte);
    send_byte(8'h02);
    // sync again in the version slot, then a one-byte frame with a bad crc
    send_frame(1'b1, 8'h00, 8'hFF, 16'd1, 1'b1, 1);
    // all-ones length, reported saturated with the length error
    send_frame(1'b0, 8'h5C, 8'hA3, 16'hFFFF, 1'b0, 0);

    // long receiver stall while the largest frame is offered
    hold_req = 1'b1;
    send_frame(1'b0, 8'($urandom), 8'($urandom), 16'd1024, 1'b0, 1024);
    run_random(150);
    // sender holds off until the block has returned everything
    drain();
    run_random(150);

    // zero limit, sync and version at opposite extremes
    drain();
    program_regs(8'h00, 8'hFF, 11'd0);
    run_random(130);

    // limit register at its top, clamped to the payload maximum; no idling
    drain();
    program_regs(8'hFF, 8'h00, 11'h7FF);
    quiet = 1'b1;
    send_frame(1'b0, 8'($urandom), 8'($urandom), 16'd1025, 1'b0, 0);
    run_random(120);
    quiet = 1'b0;

    // random codes, small random limit
    drain();
    s = 8'($urandom);
    do v = 8'($urandom); while (v == s);
    program_regs(s, v, 11'($urandom_range(1, 64)));
    run_random(110);

    // sync equal to version: a repeated sync is taken as the version
    drain();
    program_regs(8'h5A, 8'h5A, 11'd7);
    run_random(90);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
